// ----- rtl/ftco_pkg.sv -----
// ----------------------------------------------------------------------------
// ftco_pkg: shared types and constants
// Opcodes, table entry layout and CORDIC constants for the Frenet offset block.
// ----------------------------------------------------------------------------
package ftco_pkg;

   localparam int DEFAULT_MAX_POINTS = 1024;
   localparam int LEN_W              = 32;
   localparam int HEAD_W             = 16;
   localparam int CORDIC_STEPS       = 16;
   localparam int CORDIC_IW          = $clog2(CORDIC_STEPS);
   localparam int QUOT_W             = 17;

   // 0.6072529350 in Q30, start vector length
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   // atan(2^-i) in units of 2^32 per turn
   localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
      30'd42667331,  30'd21354465,  30'd10680862,  30'd5340245,
      30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
      30'd166886,    30'd83443,     30'd41722,     30'd20861
   };

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2,
      OP_RSVD   = 2'd3
   } opcode_type;

   typedef enum logic {
      CSR_LAT_OFFSET = 1'b0,
      CSR_ARC_EPS    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [HEAD_W-1:0] head;
      logic signed [LEN_W-1:0]  y;
      logic signed [LEN_W-1:0]  x;
      logic signed [LEN_W-1:0]  arc;
   } entry_type;

endpackage

// ----- rtl/frenet_to_cartesian_offset.sv -----
// ----------------------------------------------------------------------------
// frenet_to_cartesian_offset: reference line lookup with lateral offset
//
//   channel  dir  fields
//   req_     in   tuser: opcode; tdata: arc_length, point_x_in, point_y_in, heading_in
//   rsp_     out  tuser: status; tdata: out_x, out_y
//   csr_     in   index 0 lateral_offset, 1 arc_epsilon
//
// Clear, append and reserved opcodes finish in S_IDLE; an empty-table query goes
// through S_DONE to the output register. With k <= ceil(log2(n+1)) search steps
// for n stored points, an interpolated query raises rsp_tvalid after the search,
// registered table reads, 17-step divider, 16-step CORDIC and multiplies; a query
// clamped to an end point skips the divider and the interpolation multiplies.
// One item at a time; a finished result waits in the output register while the
// next item is taken, and the next result holds the input until it drains.
// Synchronous reset empties the table (count only).
// ----------------------------------------------------------------------------
module frenet_to_cartesian_offset
   import ftco_pkg::*;
#(
   parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_tuser,   // opcode
   input  logic [111:0]  req_tdata,   // arc_length, point_x_in, point_y_in, heading_in
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic          rsp_tuser,   // status
   output logic [63:0]   rsp_tdata,   // out_x, out_y
   input  logic          csr_wr_en,
   input  logic          csr_index,
   input  logic [31:0]   csr_wdata
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   typedef enum logic [15:0] {
      S_IDLE   = 16'h0001,
      S_SEARCH = 16'h0002,
      S_CMP    = 16'h0004,
      S_LOAD0  = 16'h0008,
      S_LOAD1  = 16'h0010,
      S_LOADK  = 16'h0020,
      S_DIV    = 16'h0040,
      S_MULX   = 16'h0080,
      S_MULY   = 16'h0100,
      S_MULH   = 16'h0200,
      S_HEAD   = 16'h0400,
      S_CORDIC = 16'h0800,
      S_MULS   = 16'h1000,
      S_MULC   = 16'h2000,
      S_FIN    = 16'h4000,
      S_DONE   = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]              count_ff, count_in, lo_ff, lo_in, hi_ff, hi_in;
   logic signed [LEN_W-1:0]    s_ff, s_in, s0_ff, s0_in, x0_ff, x0_in, y0_ff, y0_in;
   logic signed [LEN_W-1:0]    px_ff, px_in, py_ff, py_in, lat_ff, lat_in;
   logic signed [HEAD_W-1:0]   h0_ff, h0_in, dh_ff, dh_in;
   logic signed [LEN_W:0]      dx_ff, dx_in, dy_ff, dy_in;
   logic [LEN_W-1:0]           gap_ff, gap_in;
   logic [15:0]                eps_ff, eps_in;
   logic signed [67:0]         prod_ff, prod_in;
   logic [LEN_W-1:0]           res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic                       res_st_ff, res_st_in, rsp_valid_ff, rsp_valid_in;

   entry_type                  rd_data, wr_data;
   logic                       wr_en;
   logic [AW-1:0]              rd_addr;
   logic [CW:0]                lo_hi_sum;
   logic [CW-1:0]              mid;
   logic                       req_fire;
   opcode_type                 req_op;
   logic signed [33:0]         mul_a, mul_b;
   logic signed [67:0]         mul_p, rnd16_sum, rnd30_sum;
   logic [LEN_W-1:0]           div_t, div_gap;
   logic                       div_start, div_done;
   logic [QUOT_W-1:0]          weight;
   logic                       cor_start, cor_done;
   logic signed [HEAD_W-1:0]   cor_angle;
   logic signed [33:0]         sin_v, cos_v;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = opcode_type'(req_tuser);
   assign lo_hi_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid        = lo_hi_sum[CW:1];
   assign wr_data    = req_tdata;
   assign wr_en      = req_fire && (req_op == OP_APPEND) && (count_ff < CW'(MAX_POINTS));

   assign mul_p      = mul_a * mul_b;
   assign rnd16_sum  = prod_ff + 68'sd32768;
   assign rnd30_sum  = prod_ff + 68'sd536870912;
   assign div_t      = LEN_W'(s_ff - s0_ff);
   assign div_gap    = LEN_W'(rd_data.arc - s0_ff);

   ftco_table #(.DEPTH(MAX_POINTS), .AW(AW)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ftco_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_t),
      .divisor  (div_gap),
      .done     (div_done),
      .quotient (weight)
   );

   ftco_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .done    (cor_done),
      .sin_out (sin_v),
      .cos_out (cos_v)
   );

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MULX: begin
            mul_a = {dx_ff[LEN_W], dx_ff};
            mul_b = {17'b0, weight};
         end
         S_MULY: begin
            mul_a = {dy_ff[LEN_W], dy_ff};
            mul_b = {17'b0, weight};
         end
         S_MULH: begin
            mul_a = {{18{dh_ff[HEAD_W-1]}}, dh_ff};
            mul_b = {17'b0, weight};
         end
         S_MULS: begin
            mul_a = {{2{lat_ff[LEN_W-1]}}, lat_ff};
            mul_b = sin_v;
         end
         S_MULC: begin
            mul_a = {{2{lat_ff[LEN_W-1]}}, lat_ff};
            mul_b = cos_v;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      s_in         = s_ff;
      s0_in        = s0_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      h0_in        = h0_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dh_in        = dh_ff;
      gap_in       = gap_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      prod_in      = mul_p;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      lat_in       = lat_ff;
      eps_in       = eps_ff;
      rd_addr      = mid[AW-1:0];
      div_start    = 1'b0;
      cor_start    = 1'b0;
      cor_angle    = rd_data.head;

      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_LAT_OFFSET: lat_in = csr_wdata;
            CSR_ARC_EPS:    eps_in = csr_wdata[15:0];
            default:        lat_in = lat_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  OP_CLEAR: count_in = '0;
                  OP_APPEND: begin
                     if (wr_en) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     s_in  = req_tdata[31:0];
                     lo_in = '0;
                     hi_in = count_ff;
                     if (count_ff == '0) begin
                        res_x_in  = '0;
                        res_y_in  = '0;
                        res_st_in = 1'b1;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  default: count_in = count_ff;
               endcase
            end
         end
         S_SEARCH: begin
            if (lo_ff < hi_ff) begin
               rd_addr  = mid[AW-1:0];
               state_in = S_CMP;
            end else if (lo_ff == '0 || lo_ff == count_ff) begin
               // clamp to first or last point
               rd_addr  = (lo_ff == '0) ? '0 : AW'(count_ff - 1'b1);
               state_in = S_LOADK;
            end else begin
               rd_addr  = AW'(lo_ff - 1'b1);
               state_in = S_LOAD0;
            end
         end
         S_CMP: begin
            if (rd_data.arc < s_ff) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
            state_in = S_SEARCH;
         end
         S_LOAD0: begin
            s0_in    = rd_data.arc;
            x0_in    = rd_data.x;
            y0_in    = rd_data.y;
            h0_in    = rd_data.head;
            rd_addr  = lo_ff[AW-1:0];
            state_in = S_LOAD1;
         end
         S_LOAD1: begin
            gap_in    = div_gap;
            dx_in     = {rd_data.x[LEN_W-1], rd_data.x} - {x0_ff[LEN_W-1], x0_ff};
            dy_in     = {rd_data.y[LEN_W-1], rd_data.y} - {y0_ff[LEN_W-1], y0_ff};
            dh_in     = rd_data.head - h0_ff;
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_LOADK: begin
            px_in     = rd_data.x;
            py_in     = rd_data.y;
            cor_start = 1'b1;
            state_in  = S_CORDIC;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_MULX;
            end
         end
         S_MULX: state_in = S_MULY;
         S_MULY: begin
            px_in    = x0_ff + rnd16_sum[47:16];
            state_in = S_MULH;
         end
         S_MULH: begin
            py_in    = y0_ff + rnd16_sum[47:16];
            state_in = S_HEAD;
         end
         S_HEAD: begin
            if (gap_ff <= {16'b0, eps_ff}) begin
               cor_angle = h0_ff;
            end else begin
               cor_angle = h0_ff + rnd16_sum[31:16];
            end
            cor_start = 1'b1;
            state_in  = S_CORDIC;
         end
         S_CORDIC: begin
            if (cor_done) begin
               state_in = S_MULS;
            end
         end
         S_MULS: state_in = S_MULC;
         S_MULC: begin
            res_x_in = px_ff - rnd30_sum[61:30];
            state_in = S_FIN;
         end
         S_FIN: begin
            res_y_in  = py_ff + rnd30_sum[61:30];
            res_st_in = 1'b0;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   logic [LEN_W-1:0] rsp_x_ff, rsp_y_ff;
   logic             rsp_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         lat_ff       <= '0;
         eps_ff       <= 16'd1;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         lat_ff       <= lat_in;
         eps_ff       <= eps_in;
      end
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      s_ff      <= s_in;
      s0_ff     <= s0_in;
      x0_ff     <= x0_in;
      y0_ff     <= y0_in;
      h0_ff     <= h0_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      dh_ff     <= dh_in;
      gap_ff    <= gap_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      prod_ff   <= prod_in;
      res_x_ff  <= res_x_in;
      res_y_ff  <= res_y_in;
      res_st_ff <= res_st_in;
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_x_ff  <= res_x_ff;
         rsp_y_ff  <= res_y_ff;
         rsp_st_ff <= res_st_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_st_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("point count beyond table depth");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result shown without a finished query");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside its wait state");

   a_cordic_done: assert property (@(posedge clock) disable iff (reset)
      cor_done |-> state_ff == S_CORDIC)
      else $error("CORDIC finished outside its wait state");

endmodule

// ----- rtl/ftco_table.sv -----
// ----------------------------------------------------------------------------
// ftco_table: reference point memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ftco_table
   import ftco_pkg::*;
#(
   parameter int DEPTH = DEFAULT_MAX_POINTS,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  entry_type       wr_data,
   input  logic [AW-1:0]   rd_addr,
   output entry_type       rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ftco_div.sv -----
// ----------------------------------------------------------------------------
// ftco_div: interpolation weight divider
// Restoring divider, one quotient bit a cycle: w = (t << 16) / gap, t <= gap.
// ----------------------------------------------------------------------------
module ftco_div
   import ftco_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [LEN_W-1:0]    dividend,
   input  logic [LEN_W-1:0]    divisor,
   output logic                done,
   output logic [QUOT_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic [LEN_W+1:0]  rem_ff, rem_in;
   logic [LEN_W-1:0]  div_ff, div_in;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              first_ff, first_in;
   logic              done_ff, done_in;
   logic [LEN_W+1:0]  trial;
   logic              fits;

   // first step takes the integer bit without a shift
   assign trial = first_ff ? rem_ff : {rem_ff[LEN_W:0], 1'b0};
   assign fits  = trial >= {2'b00, div_ff};

   always_comb begin
      rem_in   = rem_ff;
      div_in   = div_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      first_in = first_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = {2'b00, dividend};
         div_in   = divisor;
         q_in     = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
         first_in = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? trial - {2'b00, div_ff} : trial;
         q_in     = {q_ff[QUOT_W-2:0], fits};
         first_in = 1'b0;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QUOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
      first_ff <= first_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ----- rtl/ftco_cordic.sv -----
// ----------------------------------------------------------------------------
// ftco_cordic: iterative sine and cosine
// One CORDIC rotation a cycle on a 16-bit heading scaled to 2^32 per turn; results Q30.
// ----------------------------------------------------------------------------
module ftco_cordic
   import ftco_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [HEAD_W-1:0]  angle,
   output logic                      done,
   output logic signed [33:0]        sin_out,
   output logic signed [33:0]        cos_out
);

   logic signed [33:0]        x_ff, x_in, y_ff, y_in;
   logic signed [32:0]        z_ff, z_in;
   logic [CORDIC_IW-1:0]      i_ff, i_in;
   logic                      busy_ff, busy_in, done_ff, done_in, flip_ff, flip_in;
   logic signed [32:0]        z0, atan_v;
   logic signed [33:0]        dxs, dys;

   assign z0     = {angle[HEAD_W-1], angle, 16'h0000};
   assign atan_v = {3'b000, ATAN_TAB[i_ff]};
   assign dxs    = y_ff >>> i_ff;
   assign dys    = x_ff >>> i_ff;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      busy_in = busy_ff;
      flip_in = flip_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         i_in    = '0;
         busy_in = 1'b1;
         // fold angles beyond a quarter turn by a half turn
         flip_in = (z0 > 33'sd1073741824) || (z0 < -33'sd1073741824);
         if (flip_in) begin
            z_in = z0[32] ? z0 + 33'sd2147483648 : z0 - 33'sd2147483648;
         end else begin
            z_in = z0;
         end
      end else if (busy_ff) begin
         if (!z_ff[32]) begin
            x_in = x_ff - dxs;
            y_in = y_ff + dys;
            z_in = z_ff - atan_v;
         end else begin
            x_in = x_ff + dxs;
            y_in = y_ff - dys;
            z_in = z_ff + atan_v;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == CORDIC_IW'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      i_ff    <= i_in;
      flip_ff <= flip_in;
   end

   assign done    = done_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;

endmodule
